FILE: rtl/pla_pkg.sv
// Shared types and constants for the point light attenuation pipeline.
`default_nettype none
package pla_pkg;

  localparam int CoordW  = 24;
  localparam int DiffW   = 25;
  localparam int D2W     = 50;
  localparam int RootW   = 31;
  localparam int RadW    = 62;
  localparam int NumW    = 32;
  localparam int DvdW    = 48;
  localparam int QuoW    = 32;
  localparam int CfgW    = 48;

  localparam logic [2:0] REG_LIGHT_ON   = 3'd0;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd1;
  localparam logic [2:0] REG_COLOR_RGB  = 3'd2;
  localparam logic [2:0] REG_LOC_X      = 3'd3;
  localparam logic [2:0] REG_LOC_Y      = 3'd4;
  localparam logic [2:0] REG_LOC_Z      = 3'd5;
  localparam logic [2:0] REG_ATT_MODE   = 3'd6;

  localparam logic [1:0] MODE_INV_DIST = 2'd1;
  localparam logic [1:0] MODE_INV_SQ   = 2'd2;

  // sideband that travels with each beat down the pipe
  typedef struct packed {
    logic       vld;
    logic       force_max;
    logic [2:0] ovf;
  } pla_tag_t;

endpackage
`default_nettype wire

FILE: rtl/point_light_attenuation_top.sv
// Point light intensity with distance attenuation, fully pipelined.
// Throughput: one beat per cycle unless stalled; the 31-stage square root and the
// 32-stage divider each retire one bit per stage.
// The whole pipe advances when the output register is empty or taken.
// Reset (rst, synchronous) empties the pipe and loads register defaults.
`default_nettype none
module point_light_attenuation_top
  import pla_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [71:0]      s_tdata,   // point_x, point_y, point_z
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [95:0]           m_tdata,   // red, green, blue
  output logic                  m_tuser,   // saturated
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CfgW-1:0]  cfg_data
);

  // configuration registers
  logic              light_on;
  logic [15:0]       brightness;
  logic [47:0]       color_rgb;
  logic [CoordW-1:0] loc_x, loc_y, loc_z;
  logic [1:0]        att_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_on   <= 1'b1;
      brightness <= 16'd256;
      color_rgb  <= '1;
      loc_x      <= '0;
      loc_y      <= '0;
      loc_z      <= '0;
      att_mode   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGHT_ON:   light_on   <= cfg_data[0];
        REG_BRIGHTNESS: brightness <= cfg_data[15:0];
        REG_COLOR_RGB:  color_rgb  <= cfg_data[47:0];
        REG_LOC_X:      loc_x      <= cfg_data[CoordW-1:0];
        REG_LOC_Y:      loc_y      <= cfg_data[CoordW-1:0];
        REG_LOC_Z:      loc_z      <= cfg_data[CoordW-1:0];
        REG_ATT_MODE:   att_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // channel products follow the registers; the user keeps them steady while beats are in flight, this is not enforced
  logic [NumW-1:0] prod [0:2];
  always_ff @(posedge clk) begin
    prod[0] <= brightness * color_rgb[47:32];
    prod[1] <= brightness * color_rgb[31:16];
    prod[2] <= brightness * color_rgb[15:0];
  end

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // stage 1: component differences
  logic                    v1;
  logic signed [DiffW-1:0] dx, dy, dz;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (ce) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      dx <= $signed({s_tdata[23], s_tdata[23:0]})  - $signed({loc_x[23], loc_x});
      dy <= $signed({s_tdata[47], s_tdata[47:24]}) - $signed({loc_y[23], loc_y});
      dz <= $signed({s_tdata[71], s_tdata[71:48]}) - $signed({loc_z[23], loc_z});
    end
  end

  // stage 2: squares
  logic                  v2;
  logic signed [D2W-1:0] sx, sy, sz;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (ce) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      sx <= dx * dx;
      sy <= dy * dy;
      sz <= dz * dz;
    end
  end

  // stage 3: squared distance and zero check
  pla_tag_t       t3;
  logic [D2W-1:0] d2;
  logic [D2W-1:0] d2_sum;
  logic           att_on;
  assign d2_sum = D2W'(sx) + D2W'(sy) + D2W'(sz);
  assign att_on = (att_mode == MODE_INV_DIST) || (att_mode == MODE_INV_SQ);
  always_ff @(posedge clk) begin
    if (rst) t3 <= '0;
    else if (ce) begin
      t3.vld       <= v2;
      t3.force_max <= light_on && att_on && (d2_sum == '0);
      t3.ovf       <= '0;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) d2 <= d2_sum;
  end

  // stages 4..34: distance
  pla_tag_t         t_rt;
  logic [D2W-1:0]   d2_rt;
  logic [RootW-1:0] root;

  pla_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_tag  (t3),
    .in_d2   (d2),
    .out_tag (t_rt),
    .out_d2  (d2_rt),
    .root    (root)
  );

  // stage 35: divider operands per mode; black via zero dividend
  logic [D2W-1:0]  dvs_next;
  logic [DvdW-1:0] dvd_next [0:2];
  logic [2:0]      ovf_next;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!light_on) dvd_next[c] = '0;
      else if (att_mode == MODE_INV_DIST) dvd_next[c] = {6'd0, prod[c], 10'd0};
      else dvd_next[c] = {prod[c], 16'd0};
    end
    if (!light_on) dvs_next = D2W'(1);
    else if (att_mode == MODE_INV_DIST) dvs_next = {{(D2W-RootW){1'b0}}, root};
    else if (att_mode == MODE_INV_SQ) dvs_next = d2_rt;
    else dvs_next = D2W'(1) << 24;
    for (int c = 0; c < 3; c++) begin
      ovf_next[c] = ({{(D2W-16){1'b0}}, dvd_next[c][DvdW-1:QuoW]} >= dvs_next);
    end
  end

  pla_tag_t        t_op;
  logic [D2W-1:0]  dvs;
  logic [DvdW-1:0] dvd [0:2];
  always_ff @(posedge clk) begin
    if (rst) t_op <= '0;
    else if (ce) begin
      t_op.vld       <= t_rt.vld;
      t_op.force_max <= t_rt.force_max;
      t_op.ovf       <= ovf_next;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      dvs <= dvs_next;
      for (int c = 0; c < 3; c++) dvd[c] <= dvd_next[c];
    end
  end

  // stages 36..67: quotients
  pla_tag_t        t_dv;
  logic [QuoW-1:0] quo [0:2];

  pla_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_tag   (t_op),
    .divisor  (dvs),
    .dividend (dvd),
    .out_tag  (t_dv),
    .quo      (quo)
  );

  // stage 68: clip and output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (ce) m_tvalid <= t_dv.vld;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) begin
        m_tdata[c*32 +: 32] <= (t_dv.force_max || t_dv.ovf[c]) ? '1 : quo[c];
      end
      m_tuser <= t_dv.force_max || (|t_dv.ovf);
    end
  end

  // a flagged beat carries at least one clipped channel
  a_sat_has_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[31:0] == '1) || (m_tdata[63:32] == '1) || (m_tdata[95:64] == '1))
    else $error("saturated beat without a clipped channel");

  // input is refused only while a finished beat waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

  // a held output beat stays valid with the same flag for the next edge
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
    else $error("stalled output beat changed");

endmodule
`default_nettype wire

FILE: rtl/pla_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module pla_sqrt
  import pla_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             ce,
  input  wire pla_tag_t         in_tag,
  input  wire logic [D2W-1:0]   in_d2,
  output pla_tag_t              out_tag,
  output logic [D2W-1:0]        out_d2,
  output logic [RootW-1:0]      root
);

  localparam int RemW = RootW + 3;

  pla_tag_t             tag_s  [0:RootW];
  logic [D2W-1:0]       d2_s   [0:RootW];
  logic [RadW-1:0]      rad_s  [0:RootW];
  logic [RemW-1:0]      rem_s  [0:RootW];
  logic [RootW-1:0]     root_s [0:RootW];

  // stage 0 is the input side
  assign tag_s[0]  = in_tag;
  assign d2_s[0]   = in_d2;
  assign rad_s[0]  = {in_d2, 12'd0};
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic [RemW+1:0] cat;
    logic [RemW+1:0] trial;
    logic            take;

    // bring down the next two radicand bits and try a one
    assign cat   = {rem_s[k], rad_s[k][RadW-1 -: 2]};
    assign trial = {3'd0, root_s[k], 2'b01};
    assign take  = (cat >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_s[k+1] <= '0;
      end else if (ce) begin
        tag_s[k+1] <= tag_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        d2_s[k+1]   <= d2_s[k];
        rad_s[k+1]  <= {rad_s[k][RadW-3:0], 2'b00};
        rem_s[k+1]  <= take ? RemW'(cat - trial) : cat[RemW-1:0];
        root_s[k+1] <= {root_s[k][RootW-2:0], take};
      end
    end
  end

  assign out_tag = tag_s[RootW];
  assign out_d2  = d2_s[RootW];
  assign root    = root_s[RootW];

endmodule
`default_nettype wire

FILE: rtl/pla_div.sv
// Pipelined restoring divider for three channels sharing one divisor.
`default_nettype none
module pla_div
  import pla_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             ce,
  input  wire pla_tag_t         in_tag,
  input  wire logic [D2W-1:0]   divisor,
  input  wire logic [DvdW-1:0]  dividend [0:2],
  output pla_tag_t              out_tag,
  output logic [QuoW-1:0]       quo [0:2]
);

  pla_tag_t         tag_s [0:QuoW];
  logic [D2W-1:0]   dv_s  [0:QuoW];
  logic [D2W-1:0]   rem_s [0:QuoW][0:2];
  logic [QuoW-1:0]  sh_s  [0:QuoW][0:2];

  // upper dividend bits start the remainder; the user keeps them below the divisor, the block does not enforce it
  assign tag_s[0] = in_tag;
  assign dv_s[0]  = divisor;
  for (genvar c = 0; c < 3; c++) begin : g_in
    assign rem_s[0][c] = {{(D2W-(DvdW-QuoW)){1'b0}}, dividend[c][DvdW-1:QuoW]};
    assign sh_s[0][c]  = dividend[c][QuoW-1:0];
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        tag_s[k+1] <= '0;
      end else if (ce) begin
        tag_s[k+1] <= tag_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        dv_s[k+1] <= dv_s[k];
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [D2W:0] cat;
      logic         take;

      assign cat  = {rem_s[k][c], sh_s[k][c][QuoW-1]};
      assign take = (cat >= {1'b0, dv_s[k]});

      // quotient bits shift in where dividend bits leave
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_s[k+1][c] <= take ? D2W'(cat - {1'b0, dv_s[k]}) : cat[D2W-1:0];
          sh_s[k+1][c]  <= {sh_s[k][c][QuoW-2:0], take};
        end
      end
    end
  end

  assign out_tag = tag_s[QuoW];
  for (genvar c = 0; c < 3; c++) begin : g_out
    assign quo[c] = sh_s[QuoW][c];
  end

endmodule
`default_nettype wire
